// ----- src/spg_pkg.sv -----
// Shared constants, types and codes for the spatial grid proximity block.
package spg_pkg;

  // Storage geometry
  localparam int MAX_CELLS      = 4096;
  localparam int CELL_BITS      = $clog2(MAX_CELLS);
  localparam int SLOTS_PER_CELL = 16;
  localparam int SLOT_BITS      = $clog2(SLOTS_PER_CELL);
  localparam int FILL_BITS      = $clog2(SLOTS_PER_CELL + 1);
  localparam int PT_ADDR_BITS   = CELL_BITS + SLOT_BITS;

  // Coordinate arithmetic
  localparam int COORD_BITS  = 16;
  localparam int POINT_BITS  = 3 * COORD_BITS;
  localparam int POS_BITS    = COORD_BITS + 2;   // doubled coordinate plus or minus reach
  localparam int MAG_BITS    = COORD_BITS + 2;   // positive offset from the doubled origin
  localparam int SIZE_BITS   = 16;
  localparam int DIVS_BITS   = SIZE_BITS + 1;    // doubled cell size
  localparam int RES_BITS    = 13;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int DIST_BITS   = SQ_BITS + 2;
  localparam int CNT_BITS    = $clog2(MAG_BITS);

  // Candidate cell list of a check
  localparam int LIST_DEPTH  = 27;
  localparam int LIST_BITS   = $clog2(LIST_DEPTH + 1);

  // Port widths
  localparam int IN_DATA_BITS  = 10 * COORD_BITS;
  localparam int OUT_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 3;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_MIN_DIST = 2'd1,
    OP_TRIANGLE = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_CELL_SIZE = 3'd3,
    CFG_RES_X     = 3'd4,
    CFG_RES_Y     = 3'd5,
    CFG_RES_Z     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic [SIZE_BITS-1:0]         cell_size;
    logic [RES_BITS-1:0]          res_x;
    logic [RES_BITS-1:0]          res_y;
    logic [RES_BITS-1:0]          res_z;
  } cfg_t;

  typedef struct packed {
    logic                 done;
    logic                 beyond;
    logic [CELL_BITS-1:0] cell_idx;
  } cu_result_t;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_DIV,
    CU_MUL,
    CU_MAC,
    CU_SUM
  } cu_state_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_GO,
    S_CELL_WAIT,
    S_FILL_RD,
    S_FILL_WAIT,
    S_PT_SQ,
    S_PT_CMP,
    S_NEXT,
    S_DONE
  } state_t;

endpackage

// ----- src/spatial_grid_proximity_top.sv -----
// Top level of the spatial grid proximity block: control, storage and stream ports.
// One word is processed at a time. After reset the block sweeps the bucket fill
// memory, one cell a cycle, through all 4096 cells before it takes its first word
// (configuration writes are taken throughout). Each cell index is computed in the
// cell unit by its bit-serial divider (18 quotient bits per axis, the three axes in
// parallel), two multiply stages and a final add. An insert then reads the fill
// count of its cell and stores the point if the cell has room; a cell beyond
// storage or a full cell drops it. A check visits each distinct cell once (27
// offsets for the minimum distance check, 3 vertices for the triangle check), skips
// cells beyond storage, and compares each stored point read from the point memory,
// against up to three vertices in turn for the triangle check. A check stops as
// soon as its answer is settled. The result word sits in an output register, so
// the next word is taken while it waits.
module spatial_grid_proximity_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [15:0]                          cfg_data,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, reach (16 bits each)
  input  logic [spg_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // op
  input  logic [1:0]                           s_tuser,
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // answer, dropped, six zero bits
  output logic [spg_pkg::OUT_DATA_BITS-1:0]    m_tdata
);
  import spg_pkg::*;

  state_t state, state_next;

  cfg_t cfg;

  // Item registers
  op_t                          op;
  logic signed [COORD_BITS-1:0] vert [3][3];
  logic [COORD_BITS-1:0]        reach;
  logic [SQ_BITS-1:0]           r2;
  logic [1:0]                   dig [3];
  logic                         answer, dropped;

  // Scan registers
  logic [CELL_BITS-1:0]         clr_addr;
  logic [CELL_BITS-1:0]         cur_cell;
  logic [CELL_BITS-1:0]         list [LIST_DEPTH];
  logic [LIST_BITS-1:0]         list_cnt;
  logic [FILL_BITS-1:0]         nfill;
  logic [SLOT_BITS-1:0]         slot;
  logic [1:0]                   vsel;
  logic [SQ_BITS-1:0]           sq [3];

  // Result register
  logic                         m_answer, m_dropped;

  // Cell unit
  logic                         cu_start;
  logic signed [POS_BITS-1:0]   pos [3];
  cu_result_t                   cu_res;

  // Memories
  logic                         fill_we, fill_re;
  logic [CELL_BITS-1:0]         fill_waddr;
  logic [FILL_BITS-1:0]         fill_wdata, fill_q;
  logic                         pt_we, pt_re;
  logic [PT_ADDR_BITS-1:0]      pt_waddr, pt_raddr;
  logic [POINT_BITS-1:0]        pt_wdata, pt_q;

  // Control strobes
  logic                         take_item, set_answer, clr_answer, set_dropped;
  logic                         list_push, step_digits, begin_scan, next_vertex;
  logic                         next_point, load_out;

  // Shared combinational values
  logic [1:0]                   vrd;
  logic                         last_cell, dup, more_pts, fill_ok;
  logic [DIST_BITS-1:0]         dist_sum;
  logic [SLOT_BITS-1:0]         slot_inc;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {(OUT_DATA_BITS-2)'(0), m_dropped, m_answer};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.origin_z  <= '0;
      cfg.cell_size <= SIZE_BITS'(256);
      cfg.res_x     <= RES_BITS'(16);
      cfg.res_y     <= RES_BITS'(16);
      cfg.res_z     <= RES_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:  cfg.origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  cfg.origin_y  <= cfg_data;
        CFG_ORIGIN_Z:  cfg.origin_z  <= cfg_data;
        CFG_CELL_SIZE: cfg.cell_size <= cfg_data;
        CFG_RES_X:     cfg.res_x     <= cfg_data[RES_BITS-1:0];
        CFG_RES_Y:     cfg.res_y     <= cfg_data[RES_BITS-1:0];
        CFG_RES_Z:     cfg.res_z     <= cfg_data[RES_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Vertex read port: scan vertex while comparing, else the cell source
  always_comb begin
    if (state == S_PT_SQ) begin
      vrd = vsel;
    end else begin
      vrd = (op == OP_TRIANGLE) ? dig[0] : 2'd0;
    end
  end

  // Doubled probe position, with the half-distance offsets of a distance check
  always_comb begin
    logic [1:0]                 dg;
    logic signed [POS_BITS-1:0] base, rext;
    rext = POS_BITS'(reach);
    for (int k = 0; k < 3; k++) begin
      dg   = dig[2-k];
      base = {vert[vrd][k][COORD_BITS-1], vert[vrd][k], 1'b0};
      if (op == OP_MIN_DIST && dg == 2'd0) begin
        pos[k] = base - rext;
      end else if (op == OP_MIN_DIST && dg == 2'd2) begin
        pos[k] = base + rext;
      end else begin
        pos[k] = base;
      end
    end
  end

  // Cell already visited by this check
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (LIST_BITS'(i) < list_cnt && list[i] == cu_res.cell_idx) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_MIN_DIST: last_cell = (dig[0] == 2'd2) && (dig[1] == 2'd2) && (dig[2] == 2'd2);
      OP_TRIANGLE: last_cell = (dig[0] == 2'd2);
      default:     last_cell = 1'b1;
    endcase
  end

  assign slot_inc = slot + SLOT_BITS'(1);
  assign more_pts = (FILL_BITS'(slot) + FILL_BITS'(1)) < nfill;
  assign fill_ok  = fill_q < FILL_BITS'(SLOTS_PER_CELL);
  assign dist_sum = DIST_BITS'(sq[0]) + DIST_BITS'(sq[1]) + DIST_BITS'(sq[2]);

  // Next state, strobes and memory controls
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cu_start    = 1'b0;
    take_item   = 1'b0;
    set_answer  = 1'b0;
    clr_answer  = 1'b0;
    set_dropped = 1'b0;
    list_push   = 1'b0;
    step_digits = 1'b0;
    begin_scan  = 1'b0;
    next_vertex = 1'b0;
    next_point  = 1'b0;
    load_out    = 1'b0;
    fill_we     = 1'b0;
    fill_re     = 1'b0;
    fill_waddr  = cur_cell;
    fill_wdata  = fill_q + FILL_BITS'(1);
    pt_we       = 1'b0;
    pt_re       = 1'b0;
    pt_waddr    = {cur_cell, fill_q[SLOT_BITS-1:0]};
    pt_raddr    = {cur_cell, slot_inc};
    unique case (state)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_addr;
        fill_wdata = '0;
        if (clr_addr == CELL_BITS'(MAX_CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          take_item = 1'b1;
          state_next = (op_t'(s_tuser) == OP_UNUSED) ? S_DONE : S_CELL_GO;
        end
      end
      S_CELL_GO: begin
        cu_start   = 1'b1;
        state_next = S_CELL_WAIT;
      end
      S_CELL_WAIT: begin
        if (cu_res.done) begin
          if (op == OP_INSERT) begin
            if (cu_res.beyond) begin
              set_dropped = 1'b1;
              state_next  = S_DONE;
            end else begin
              state_next = S_FILL_RD;
            end
          end else if (cu_res.beyond || dup) begin
            state_next = S_NEXT;
          end else begin
            list_push  = 1'b1;
            state_next = S_FILL_RD;
          end
        end
      end
      S_FILL_RD: begin
        fill_re    = 1'b1;
        state_next = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        if (op == OP_INSERT) begin
          if (fill_ok) begin
            fill_we    = 1'b1;
            pt_we      = 1'b1;
            set_answer = 1'b1;
          end else begin
            set_dropped = 1'b1;
          end
          state_next = S_DONE;
        end else if (fill_q == '0) begin
          state_next = S_NEXT;
        end else begin
          begin_scan = 1'b1;
          pt_re      = 1'b1;
          pt_raddr   = {cur_cell, SLOT_BITS'(0)};
          state_next = S_PT_SQ;
        end
      end
      S_PT_SQ: state_next = S_PT_CMP;
      S_PT_CMP: begin
        if (op == OP_MIN_DIST && dist_sum < DIST_BITS'(r2)) begin
          clr_answer = 1'b1;
          state_next = S_DONE;
        end else if (op == OP_TRIANGLE && dist_sum <= DIST_BITS'(r2) && vsel != 2'd2) begin
          next_vertex = 1'b1;
          state_next  = S_PT_SQ;
        end else if (op == OP_TRIANGLE && dist_sum <= DIST_BITS'(r2)) begin
          set_answer = 1'b1;
          state_next = S_DONE;
        end else if (more_pts) begin
          next_point = 1'b1;
          pt_re      = 1'b1;
          state_next = S_PT_SQ;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_cell) begin
          state_next = S_DONE;
        end else begin
          step_digits = 1'b1;
          state_next  = S_CELL_GO;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: clear sweep and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + CELL_BITS'(1);
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item and scan datapath
  always_ff @(posedge clk) begin
    logic [1:0] carry;
    if (take_item) begin
      op <= op_t'(s_tuser);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          vert[i][k] <= s_tdata[(i*3+k)*COORD_BITS +: COORD_BITS];
        end
      end
      reach    <= s_tdata[9*COORD_BITS +: COORD_BITS];
      r2       <= s_tdata[9*COORD_BITS +: COORD_BITS] * s_tdata[9*COORD_BITS +: COORD_BITS];
      answer   <= (op_t'(s_tuser) == OP_MIN_DIST);
      dropped  <= 1'b0;
      list_cnt <= '0;
      for (int i = 0; i < 3; i++) dig[i] <= 2'd0;
    end
    if (set_answer)  answer  <= 1'b1;
    if (clr_answer)  answer  <= 1'b0;
    if (set_dropped) dropped <= 1'b1;
    if (state == S_CELL_WAIT && cu_res.done) cur_cell <= cu_res.cell_idx;
    if (list_push) begin
      list[list_cnt] <= cu_res.cell_idx;
      list_cnt <= list_cnt + LIST_BITS'(1);
    end
    // Advance the offset odometer, or the vertex of a triangle check
    if (step_digits) begin
      carry = 2'b01;
      for (int i = 0; i < 3; i++) begin
        if (carry[0]) begin
          if (dig[i] == 2'd2) begin
            dig[i] <= 2'd0;
          end else begin
            dig[i] <= dig[i] + 2'd1;
            carry = 2'b00;
          end
        end
      end
    end
    if (begin_scan) begin
      nfill <= fill_q;
      slot  <= '0;
      vsel  <= 2'd0;
    end
    if (next_vertex) vsel <= vsel + 2'd1;
    if (next_point) begin
      slot <= slot_inc;
      vsel <= 2'd0;
    end
    if (load_out) begin
      m_answer  <= answer;
      m_dropped <= dropped;
    end
  end

  // Squared axis distances of the stored point to the current vertex
  always_ff @(posedge clk) begin
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        mag;
    if (state == S_PT_SQ) begin
      for (int k = 0; k < 3; k++) begin
        diff = {pt_q[k*COORD_BITS + COORD_BITS-1], pt_q[k*COORD_BITS +: COORD_BITS]}
             - {vert[vrd][k][COORD_BITS-1], vert[vrd][k]};
        mag  = diff[COORD_BITS] ? -diff : diff;
        sq[k] <= mag[COORD_BITS-1:0] * mag[COORD_BITS-1:0];
      end
    end
  end

  assign pt_wdata = {vert[0][2], vert[0][1], vert[0][0]};

  spg_cell u_cell (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (cu_start),
    .pos   (pos),
    .res   (cu_res)
  );

  spg_ram #(
    .WIDTH (FILL_BITS),
    .DEPTH (MAX_CELLS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (cur_cell),
    .rdata (fill_q)
  );

  spg_ram #(
    .WIDTH (POINT_BITS),
    .DEPTH (MAX_CELLS * SLOTS_PER_CELL)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_q)
  );

endmodule

// ----- src/spg_ram.sv -----
// Generic single write, single read RAM with registered read data.
module spg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/spg_cell.sv -----
// Cell index unit: per-axis bit-serial division, clamping and linearisation.
module spg_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spg_pkg::cfg_t                        cfg,
  input  logic                                 start,
  input  logic signed [spg_pkg::POS_BITS-1:0]  pos [3],
  output spg_pkg::cu_result_t                  res
);
  import spg_pkg::*;

  cu_state_t state, state_next;

  logic signed [COORD_BITS-1:0] org [3];
  logic [RES_BITS-1:0]          rmax [3];
  logic [RES_BITS-1:0]          rx_eff, ry_eff;
  logic [DIVS_BITS-1:0]         dvs;

  logic [MAG_BITS-1:0]          dq  [3];
  logic [DIVS_BITS-1:0]         rem [3];
  logic                         neg [3];
  logic [CNT_BITS-1:0]          cnt;

  logic [RES_BITS-1:0]          idx [3];
  logic [RES_BITS-1:0]          ix, iz;
  logic [2*RES_BITS-1:0]        prod_y, rxy;
  logic [2*RES_BITS:0]          acc;
  logic [3*RES_BITS-1:0]        prod_z;
  logic [3*RES_BITS:0]          total;

  // Result registers
  logic                         done_q, beyond_q;
  logic [CELL_BITS-1:0]         cell_q;

  assign res = '{done: done_q, beyond: beyond_q, cell_idx: cell_q};

  // Effective configuration: zero size or resolution acts as one
  always_comb begin
    org[0] = cfg.origin_x;
    org[1] = cfg.origin_y;
    org[2] = cfg.origin_z;
    rmax[0] = (cfg.res_x == '0) ? '0 : cfg.res_x - RES_BITS'(1);
    rmax[1] = (cfg.res_y == '0) ? '0 : cfg.res_y - RES_BITS'(1);
    rmax[2] = (cfg.res_z == '0) ? '0 : cfg.res_z - RES_BITS'(1);
    rx_eff = (cfg.res_x == '0) ? RES_BITS'(1) : cfg.res_x;
    ry_eff = (cfg.res_y == '0) ? RES_BITS'(1) : cfg.res_y;
    dvs = {((cfg.cell_size == '0) ? SIZE_BITS'(1) : cfg.cell_size), 1'b0};
  end

  // Clamp each quotient to the grid
  always_comb begin
    logic [MAG_BITS-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = neg[k] ? '0 : dq[k];
      idx[k] = (q > MAG_BITS'(rmax[k])) ? rmax[k] : q[RES_BITS-1:0];
    end
  end

  assign total = (3*RES_BITS+1)'(prod_z) + (3*RES_BITS+1)'(acc);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CU_IDLE: if (start) state_next = CU_DIV;
      CU_DIV:  if (cnt == CNT_BITS'(MAG_BITS - 1)) state_next = CU_MUL;
      CU_MUL:  state_next = CU_MAC;
      CU_MAC:  state_next = CU_SUM;
      CU_SUM:  state_next = CU_IDLE;
      default: state_next = CU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state == CU_SUM);
    end
  end

  // Datapath: load offsets, divide one bit a cycle, then linearise
  always_ff @(posedge clk) begin
    logic signed [POS_BITS:0] dlin;
    logic [DIVS_BITS:0]       tmp;
    logic [DIVS_BITS:0]       sub;
    logic                     ge;
    case (state)
      CU_IDLE: begin
        cnt <= '0;
        for (int k = 0; k < 3; k++) begin
          dlin = {pos[k][POS_BITS-1], pos[k]}
               - {{2{org[k][COORD_BITS-1]}}, org[k], 1'b0};
          neg[k] <= dlin[POS_BITS] || (dlin == '0);
          dq[k]  <= dlin[MAG_BITS-1:0];
          rem[k] <= '0;
        end
      end
      CU_DIV: begin
        cnt <= cnt + CNT_BITS'(1);
        for (int k = 0; k < 3; k++) begin
          tmp = {rem[k], dq[k][MAG_BITS-1]};
          sub = tmp - {1'b0, dvs};
          ge  = (tmp >= {1'b0, dvs});
          rem[k] <= ge ? sub[DIVS_BITS-1:0] : tmp[DIVS_BITS-1:0];
          dq[k]  <= {dq[k][MAG_BITS-2:0], ge};
        end
      end
      CU_MUL: begin
        ix     <= idx[0];
        iz     <= idx[2];
        prod_y <= idx[1] * rx_eff;
        rxy    <= rx_eff * ry_eff;
      end
      CU_MAC: begin
        acc    <= (2*RES_BITS+1)'(ix) + (2*RES_BITS+1)'(prod_y);
        prod_z <= iz * rxy;
      end
      CU_SUM: begin
        cell_q   <= total[CELL_BITS-1:0];
        beyond_q <= |total[3*RES_BITS:CELL_BITS];
      end
      default: ;
    endcase
  end

endmodule
